@@ sv/smp_pkg.sv @@
// Shared constants and types for the substring match block.
package smp_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int POS_BITS    = 16;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int CFG_W       = 64;
    localparam int FIELD_W     = 16;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WIN_DEPTH   = MAX_PATTERN - 1;
    localparam int CALC_W      = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 2;
    localparam int CFG_IDX_W   = 2;

    typedef logic [BYTE_W-1:0]                  byte_t;
    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_t;
    typedef logic [LEN_W-1:0]                   len_t;
    typedef logic [POS_BITS-1:0]                pos_t;
    typedef logic [FIELD_W-1:0]                 field_t;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } cfg_idx_t;

    // Pattern as seen by the cells
    typedef struct packed {
        pat_t pattern;
        len_t length;
    } pat_cfg_t;

endpackage

@@ sv/smp_cell.sv @@
// One window cell: holds a past text byte and checks it against its pattern byte.
module smp_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic                 clear,
    input  smp_pkg::byte_t       byte_in,
    input  logic [smp_pkg::IDX_W-1:0] cell_idx,
    input  smp_pkg::pat_cfg_t    pat_cfg,
    input  logic                 match_in,
    output smp_pkg::byte_t       byte_out,
    output logic                 match_out
);
    import smp_pkg::*;

    byte_t             byte_reg;
    logic [CALC_W-1:0] sel;
    logic              in_use;
    byte_t             pat_byte;

    // Cell j holds the byte j+1 places back; it meets pattern byte len-2-j.
    always_comb begin
        sel      = CALC_W'(pat_cfg.length) - CALC_W'(cell_idx) - CALC_W'(2);
        in_use   = (CALC_W'(cell_idx) + CALC_W'(2)) <= CALC_W'(pat_cfg.length);
        pat_byte = pat_cfg.pattern[sel[IDX_W-1:0]];
    end

    assign match_out = match_in & (!in_use || (pat_byte == byte_reg));
    assign byte_out  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else if (clear) begin
            byte_reg <= '0;
        end else if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

endmodule

@@ sv/substring_match_positions.sv @@
// Top level: streaming matcher built from a chain of window cells.
//
// Text words arrive on the s_ channel (s_text_byte, s_last_byte) under
// valid/ready. Every accepted word gives exactly one result word on the
// m_ channel: match_found, the 1-based start and end positions of an
// occurrence ending at this byte, the running match count and text_done.
// The pattern (up to 16 bytes) and its length are set through the write
// port cfg_wr_en / cfg_index / cfg_data, by the user only while no text
// is in flight; the block does not enforce this. The result is registered
// and shows in the cycle after its word is accepted. Throughput: one word
// per cycle; all window cells compare in parallel in the accept cycle and
// shift the window by one byte. The receiver may stall: s_ready follows
// the output register, which frees as its word is taken, so a word is
// still taken in the same cycle that the pending result leaves. A held
// result stays stable. Reset clears the pattern, the length (no matches),
// the window, the position and the count. A word with last set closes the
// text and clears position, window and count for the next one.
module substring_match_positions (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [smp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_text_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_match_found,
    output logic [15:0]                   m_start_pos,
    output logic [15:0]                   m_end_pos,
    output logic [15:0]                   m_match_count,
    output logic                          m_text_done
);
    import smp_pkg::*;

    localparam int PAT_W = MAX_PATTERN * BYTE_W;
    localparam pos_t   POS_MAX   = {POS_BITS{1'b1}};
    localparam field_t COUNT_MAX = {FIELD_W{1'b1}};

    logic [CFG_W-1:0] pat_low_reg;
    logic [CFG_W-1:0] pat_high_reg;
    len_t             pat_len_reg;
    pat_cfg_t         pat_cfg;

    pos_t   pos_reg, pos_next;
    field_t count_reg, count_next;
    pos_t   pos_now;
    pos_t   start_now;
    logic   len_ok;
    logic   hit;
    logic   accept;

    byte_t  win [0:WIN_DEPTH];
    logic   chain [0:WIN_DEPTH];

    logic   m_valid_reg;
    logic   match_reg;
    field_t start_reg;
    field_t end_reg;
    field_t count_out_reg;
    logic   done_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_cfg.pattern = pat_t'(PAT_W'({pat_high_reg, pat_low_reg}));
    assign pat_cfg.length  = pat_len_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // newest byte enters the chain; the last pattern byte is checked here
    assign win[0]   = s_text_byte;
    assign chain[0] = (pat_len_reg != '0) &&
                      (pat_cfg.pattern[IDX_W'(pat_len_reg - len_t'(1))] == s_text_byte);

    genvar g;
    generate
        for (g = 0; g < WIN_DEPTH; g++) begin : g_cell
            smp_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (accept),
                .clear     (accept && s_last_byte),
                .byte_in   (win[g]),
                .cell_idx  (IDX_W'(g)),
                .pat_cfg   (pat_cfg),
                .match_in  (chain[g]),
                .byte_out  (win[g+1]),
                .match_out (chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        pos_now   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + pos_t'(1);
        len_ok    = (32'(pat_len_reg) >= 32'd1) && (32'(pat_len_reg) <= MAX_PATTERN);
        hit       = len_ok && (32'(pos_now) >= 32'(pat_len_reg)) && chain[WIN_DEPTH];
        start_now = pos_now - pos_t'(pat_len_reg) + pos_t'(1);
        count_next = count_reg;
        if (hit && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + field_t'(1);
        end
        pos_next = pos_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                pos_reg   <= '0;
                count_reg <= '0;
            end else begin
                pos_reg   <= pos_next;
                count_reg <= count_next;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            match_reg     <= hit;
            start_reg     <= hit ? field_t'(start_now) : '0;
            end_reg       <= hit ? field_t'(pos_now) : '0;
            count_out_reg <= count_next;
            done_reg      <= s_last_byte;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_found = match_reg;
    assign m_start_pos   = start_reg;
    assign m_end_pos     = end_reg;
    assign m_match_count = count_out_reg;
    assign m_text_done   = done_reg;

endmodule
